// ===== src/wual_pkg.sv =====
// shared types and constants for the antialiased line rasterizer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package wual_pkg;
    localparam int COORD_BITS = 6;
    localparam int FRAC_BITS  = 16;
    localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 2;
    localparam int NUM_BITS   = COORD_BITS + FRAC_BITS;

    typedef struct packed {
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
    } line_in_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] main_x;
        logic [COORD_BITS-1:0] main_y;
        logic signed [7:0]     side_x;
        logic signed [7:0]     side_y;
        logic [7:0]            main_level;
        logic [7:0]            side_level;
        logic                  side_valid;
        logic                  last;
    } pix_out_t;

    // classified line handed from front to back
    typedef struct packed {
        logic [COORD_BITS-1:0] mstart;
        logic [COORD_BITS-1:0] mend;
        logic [COORD_BITS-1:0] nstart;
        logic [COORD_BITS-1:0] adm;
        logic [COORD_BITS-1:0] dmaj;
        logic                  neg;
        logic                  x_major;
        logic                  fallback;
    } job_t;
endpackage
`default_nettype wire

// ===== src/wual_front.sv =====
// front end: accepts a line, orders endpoints and picks the major axis
// depends on wual_pkg
`timescale 1ns / 1ps
`default_nettype none
module wual_front (
    input  wire               aclk,
    input  wire               aresetn,
    input  wual_pkg::line_in_t s_line,
    input  wire               s_valid,
    output logic              s_ready,
    output wual_pkg::job_t    job,
    output logic              job_valid,
    input  wire               job_ready
);
    localparam int CB = wual_pkg::COORD_BITS;
    logic signed [CB:0] dx, dy;
    logic [CB-1:0] adx, ady;
    logic fb, xm, sw;
    logic [CB-1:0] ms, me, ns, ne;
    logic signed [CB:0] dmin;
    wual_pkg::job_t job_reg, job_next;
    logic vld_reg;

    always_comb begin
        dx = $signed({1'b0, s_line.end_x}) - $signed({1'b0, s_line.start_x});
        dy = $signed({1'b0, s_line.end_y}) - $signed({1'b0, s_line.start_y});
        adx = dx[CB] ? CB'(-dx) : dx[CB-1:0];
        ady = dy[CB] ? CB'(-dy) : dy[CB-1:0];
        fb = (dx == '0) || (dy == '0);
        xm = fb ? (dy == '0 && dx != '0) : (adx > ady);
        if (xm) begin
            sw = s_line.start_x > s_line.end_x;
            ms = sw ? s_line.end_x : s_line.start_x;
            me = sw ? s_line.start_x : s_line.end_x;
            ns = sw ? s_line.end_y : s_line.start_y;
            ne = sw ? s_line.start_y : s_line.end_y;
        end else begin
            sw = s_line.start_y > s_line.end_y;
            ms = sw ? s_line.end_y : s_line.start_y;
            me = sw ? s_line.start_y : s_line.end_y;
            ns = sw ? s_line.end_x : s_line.start_x;
            ne = sw ? s_line.start_x : s_line.end_x;
        end
        dmin = $signed({1'b0, ne}) - $signed({1'b0, ns});
        job_next.mstart   = ms;
        job_next.mend     = me;
        job_next.nstart   = ns;
        job_next.adm      = dmin[CB] ? CB'(-dmin) : dmin[CB-1:0];
        job_next.dmaj     = me - ms;
        job_next.neg      = dmin[CB];
        job_next.x_major  = xm;
        job_next.fallback = fb;
    end

    assign s_ready   = !vld_reg || job_ready;
    assign job       = job_reg;
    assign job_valid = vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_ready) begin
            vld_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            job_reg <= job_next;
        end
    end
endmodule
`default_nettype wire

// ===== src/wual_back.sv =====
// back end: divides for the slope, then walks the major axis one step a cycle while the output is not stalled
// depends on wual_pkg
`timescale 1ns / 1ps
`default_nettype none
module wual_back (
    input  wire                aclk,
    input  wire                aresetn,
    input  wual_pkg::job_t     job,
    input  wire                job_valid,
    output logic               job_ready,
    output wual_pkg::pix_out_t m_pix,
    output logic               m_valid,
    input  wire                m_ready
);
    localparam int CB = wual_pkg::COORD_BITS;
    localparam int FB = wual_pkg::FRAC_BITS;
    localparam int AB = wual_pkg::ACC_BITS;
    localparam int NB = wual_pkg::NUM_BITS;
    localparam int DCB = $clog2(NB + 1);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    logic [1:0] state_reg, state_next;
    wual_pkg::job_t jb_reg;
    logic [NB-1:0] quo_reg, quo_next;
    logic [CB:0] rem_reg, rem_next;
    logic [DCB-1:0] cnt_reg, cnt_next;
    logic [DCB-1:0] bit_idx;
    logic [CB:0] major_pos_reg, major_pos_next;
    logic signed [AB-1:0] acc_reg, acc_next, slope;
    logic [CB:0] trial;
    logic [NB-1:0] num;
    logic signed [AB-FB-1:0] fl;
    logic [FB-1:0] fr;
    logic [FB:0] alpha;
    logic [8:0] a_hi;
    logic [7:0] a8;
    logic signed [7:0] flw, side_min;
    logic step_last, out_free;
    wual_pkg::pix_out_t pix_next, pix_reg;
    logic mv_reg;

    assign out_free  = !mv_reg || m_ready;
    assign job_ready = (state_reg == ST_IDLE);
    assign m_pix     = pix_reg;
    assign m_valid   = mv_reg;

    always_comb begin
        num   = {jb_reg.adm, {FB{1'b0}}};
        bit_idx = DCB'(NB - 1) - cnt_reg;
        trial = {rem_reg[CB-1:0], num[bit_idx]};
        slope = jb_reg.neg ? -AB'($signed({1'b0, quo_reg}))
                           : AB'($signed({1'b0, quo_reg}));
        fl    = acc_reg[AB-1:FB];
        fr    = acc_reg[FB-1:0];
        alpha = jb_reg.neg ? ((FB+1)'(1) << FB) - {1'b0, fr} : {1'b0, fr};
        a_hi  = alpha[FB:FB-8];
        a8    = (a_hi > 9'd255) ? 8'd255 : a_hi[7:0];
        flw   = 8'(fl);
        side_min = jb_reg.neg ? flw - 8'sd1 : flw + 8'sd1;
        step_last = (major_pos_reg[CB-1:0] == jb_reg.mend);

        if (jb_reg.fallback) begin
            pix_next.main_x = jb_reg.x_major ? major_pos_reg[CB-1:0] : jb_reg.nstart;
            pix_next.main_y = jb_reg.x_major ? jb_reg.nstart : major_pos_reg[CB-1:0];
            pix_next.side_x = '0;
            pix_next.side_y = '0;
            pix_next.main_level = 8'd255;
            pix_next.side_level = 8'd0;
            pix_next.side_valid = 1'b0;
        end else begin
            pix_next.main_x = jb_reg.x_major ? major_pos_reg[CB-1:0] : fl[CB-1:0];
            pix_next.main_y = jb_reg.x_major ? fl[CB-1:0] : major_pos_reg[CB-1:0];
            pix_next.side_x = jb_reg.x_major ? 8'(major_pos_reg) : side_min;
            pix_next.side_y = jb_reg.x_major ? side_min : 8'(major_pos_reg);
            pix_next.main_level = 8'd255 - a8;
            pix_next.side_level = a8;
            pix_next.side_valid = 1'b1;
        end
        pix_next.last = step_last;

        state_next = state_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        major_pos_next = major_pos_reg;
        acc_next = acc_reg;
        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    state_next = ST_DIV;
                    quo_next = '0;
                    rem_next = '0;
                    cnt_next = '0;
                end
            end
            ST_DIV: begin
                // restoring division, one quotient bit a cycle
                if (jb_reg.fallback || jb_reg.dmaj == '0) begin
                    quo_next = '0;
                    cnt_next = DCB'(NB);
                end else if (trial >= {1'b0, jb_reg.dmaj}) begin
                    rem_next = trial - {1'b0, jb_reg.dmaj};
                    quo_next = {quo_reg[NB-2:0], 1'b1};
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    rem_next = trial;
                    quo_next = {quo_reg[NB-2:0], 1'b0};
                    cnt_next = cnt_reg + 1'b1;
                end
                if (cnt_next == DCB'(NB)) begin
                    state_next = ST_RUN;
                    major_pos_next = {1'b0, jb_reg.mstart};
                    acc_next = AB'($signed({1'b0, jb_reg.nstart, {FB{1'b0}}}));
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    major_pos_next = major_pos_reg + 1'b1;
                    acc_next = acc_reg + slope;
                    if (step_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg <= 1'b0;
            quo_reg <= '0;
            rem_reg <= '0;
            cnt_reg <= '0;
            major_pos_reg <= '0;
            acc_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_RUN && out_free) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_next;
            major_pos_reg <= major_pos_next;
            acc_reg <= acc_next;
        end
        if (state_reg == ST_IDLE && job_valid) begin
            jb_reg <= job;
        end
        if (state_reg == ST_RUN && out_free) begin
            pix_reg <= pix_next;
        end
    end
endmodule
`default_nettype wire

// ===== src/wu_antialiased_line_raster_core.sv =====
// Antialiased line rasterizer. A line enters as two endpoints on a 64x64 grid
// and leaves as one request per major-axis step, lowest major coordinate first,
// each with a main and a side pixel and their coverage levels (the side pixel
// is marked not valid for an axis-aligned line or a single point). Each line is
// registered in the front end, handed to the back end, run through the serial
// slope divider (cut short for an axis-aligned line or a single point), then
// walked one step per cycle (up to 64 steps) while the output is not stalled;
// a second line waits in the front register meanwhile.
// depends on wual_pkg, wual_front, wual_back
`timescale 1ns / 1ps
`default_nettype none
module wu_antialiased_line_raster_core (
    input  wire                aclk,
    input  wire                aresetn,
    input  wual_pkg::line_in_t s_line,
    input  wire                s_valid,
    output logic               s_ready,
    output wual_pkg::pix_out_t m_pix,
    output logic               m_valid,
    input  wire                m_ready
);
    wual_pkg::job_t job;
    logic job_valid, job_ready;

    wual_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_line(s_line), .s_valid(s_valid),
        .s_ready(s_ready), .job(job), .job_valid(job_valid), .job_ready(job_ready)
    );

    wual_back u_back (
        .aclk(aclk), .aresetn(aresetn), .job(job), .job_valid(job_valid),
        .job_ready(job_ready), .m_pix(m_pix), .m_valid(m_valid), .m_ready(m_ready)
    );
endmodule
`default_nettype wire

// ===== dv/tb_wu_antialiased_line_raster_core.sv =====
// testbench for the antialiased line rasterizer: random and directed lines,
// results checked against an in-bench fixed-point line predictor
// depends on wual_pkg and wu_antialiased_line_raster_core
`timescale 1ns / 1ps
`default_nettype none
module tb_wu_antialiased_line_raster_core;

    localparam int N_RANDOM = 350;

    class pixel_scoreboard;
        wual_pkg::pix_out_t pending[$];
        int       mismatches;

        // expand one line into its pixel requests
        function void note_line(wual_pkg::line_in_t ln);
            int x1, y1, x2, y2, dx, dy, adx, ady;
            int ms, me, ns, ne, dmaj, dmin, q, fl, fr, alpha, a8;
            longint accum, slope;
            bit fb, xmaj, neg;
            wual_pkg::pix_out_t p;
            x1 = ln.start_x; y1 = ln.start_y; x2 = ln.end_x; y2 = ln.end_y;
            dx = x2 - x1; dy = y2 - y1;
            adx = dx < 0 ? -dx : dx;
            ady = dy < 0 ? -dy : dy;
            fb = (dx == 0 || dy == 0);
            xmaj = fb ? (dy == 0 && dx != 0) : (adx > ady);
            if (xmaj) begin
                if (x1 <= x2) begin
                    ms = x1; me = x2; ns = y1; ne = y2;
                end else begin
                    ms = x2; me = x1; ns = y2; ne = y1;
                end
            end else begin
                if (y1 <= y2) begin
                    ms = y1; me = y2; ns = x1; ne = x2;
                end else begin
                    ms = y2; me = y1; ns = x2; ne = x1;
                end
            end
            dmaj = me - ms;
            dmin = ne - ns;
            neg = dmin < 0;
            if (fb || dmaj == 0) begin
                slope = 0;
            end else begin
                q = ((neg ? -dmin : dmin) << wual_pkg::FRAC_BITS) / dmaj;
                slope = neg ? -q : q;
            end
            accum = longint'(ns) << wual_pkg::FRAC_BITS;
            for (int m = ms; m <= me; m++) begin
                p = '0;
                p.last = (m == me);
                if (fb) begin
                    p.main_x = 6'(xmaj ? m : ns);
                    p.main_y = 6'(xmaj ? ns : m);
                    p.main_level = 8'd255;
                end else begin
                    fl = int'(accum >>> wual_pkg::FRAC_BITS);   // floor
                    fr = int'(accum - (longint'(fl) << wual_pkg::FRAC_BITS));
                    alpha = neg ? ((1 << wual_pkg::FRAC_BITS) - fr) : fr;
                    a8 = alpha >> (wual_pkg::FRAC_BITS - 8);
                    if (a8 > 255) a8 = 255;
                    p.side_level = 8'(a8);
                    p.main_level = 8'(255 - a8);
                    p.side_valid = 1'b1;
                    if (xmaj) begin
                        p.main_x = 6'(m); p.main_y = 6'(fl);
                        p.side_x = 8'(m); p.side_y = 8'(fl + (neg ? -1 : 1));
                    end else begin
                        p.main_x = 6'(fl); p.main_y = 6'(m);
                        p.side_x = 8'(fl + (neg ? -1 : 1)); p.side_y = 8'(m);
                    end
                    accum += slope;
                end
                pending.push_back(p);
            end
        endfunction

        function void check_pixel(wual_pkg::pix_out_t got);
            wual_pkg::pix_out_t exp_p;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected request %p", got);
                return;
            end
            exp_p = pending.pop_front();
            if (got !== exp_p) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: exp %p got %p", exp_p, got);
            end
        endfunction
    endclass

    logic     aclk;
    logic     aresetn;
    wual_pkg::line_in_t s_line;
    logic     s_valid;
    logic     s_ready;
    wual_pkg::pix_out_t m_pix;
    logic     m_valid;
    logic     m_ready;
    pixel_scoreboard sb;

    wu_antialiased_line_raster_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_line(s_line), .s_valid(s_valid), .s_ready(s_ready),
        .m_pix(m_pix), .m_valid(m_valid), .m_ready(m_ready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("FAILED: results differ");
        $finish;
    end

    // random gaps, with a back-to-back stretch mixed in
    function automatic int gap_len(int idx);
        if ((idx / 40) % 3 == 1) return 0;
        return $urandom_range(0, 18);
    endfunction

    // entered and left at a falling edge
    task automatic send_line(wual_pkg::line_in_t ln, int idx);
        int gap;
        gap = gap_len(idx);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_line  <= ln;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_line(ln);
        @(negedge aclk);
    endtask

    function automatic wual_pkg::line_in_t rand_line();
        wual_pkg::line_in_t ln;
        int k;
        ln = 24'($urandom);
        k = $urandom_range(0, 9);
        if (k == 0) ln.end_x = ln.start_x;
        else if (k == 1) ln.end_y = ln.start_y;
        else if (k < 5) begin
            // short lines keep the run fast
            ln.end_x = 6'(ln.start_x + $urandom_range(0, 8) - 4);
            ln.end_y = 6'(ln.start_y + $urandom_range(0, 8) - 4);
        end
        return ln;
    endfunction

    // result side: random stalls, sampled at the rising edge
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            int stall;
            stall = ((($time / 20000) % 4) == 2) ? 0 : int'($urandom_range(0, 18));
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_pixel(m_pix);
            @(negedge aclk);
        end
    end

    initial begin
        wual_pkg::line_in_t dir[$];
        int wait_cnt;
        sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_line  = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // corners, single points, axis lines, diagonals, steep/shallow, off-grid sides
        dir = '{ '{0,0,0,0}, '{63,63,63,63}, '{0,0,63,0}, '{63,5,0,5},
                 '{7,0,7,63}, '{9,63,9,0}, '{0,0,63,63}, '{63,63,0,0},
                 '{0,63,63,0}, '{63,0,0,63}, '{0,0,63,1}, '{0,63,63,62},
                 '{0,0,1,63}, '{63,0,62,63}, '{3,10,10,7}, '{10,3,7,10},
                 '{0,0,3,2}, '{0,2,3,0}, '{20,20,17,25}, '{63,63,60,62},
                 '{42,21,21,42} };
        foreach (dir[i]) send_line(dir[i], i);
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2) begin
                s_valid <= 1'b0;
                @(negedge aclk);
                while (sb.pending.size() != 0) @(negedge aclk);
            end
            send_line(rand_line(), i);
        end
        s_valid <= 1'b0;
        wait_cnt = 0;
        while (sb.pending.size() != 0 && wait_cnt < 100000) begin
            @(negedge aclk);
            wait_cnt++;
        end
        repeat (120) @(negedge aclk);
        if (sb.pending.size() == 0 && sb.mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
`default_nettype wire
